// ===== hdl/selective_repeat_receive_window_macros.svh =====
// Assertion macros for the receive window
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH

// same-cycle implication
`define SRRW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srrw assertion failed");

// next-cycle implication
`define SRRW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srrw assertion failed");

`endif

// ===== hdl/srrw_pkg.sv =====
package srrw_pkg;

    localparam int OFFSET_W    = 32;
    localparam int LENGTH_W    = 11;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_CNT_W   = 1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic [OFFSET_W-1:0] seq_offset;
        logic [LENGTH_W-1:0] payload_length;
    } in_word_t;

    typedef struct packed {
        logic [31:0] ack_count;
        logic        ack_valid;
        logic        store_payload;
        logic        transfer_done;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic clear_step;
        logic rd_slot;
        logic set_mark;
        logic advance;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic div_last;
        logic fwd;
        logic in_window;
        logic mark_set;
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/srrw_ctrl.sv =====
module srrw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    input  srrw_pkg::status_t status,
    output srrw_pkg::cmd_t    cmd,
    output logic              rx_stall
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_LOOKUP,
        S_MARK,
        S_WALK_RD,
        S_WALK,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (status.len_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                cmd.rd_slot = 1'b1;
                if (!status.fwd)
                begin
                    state_next = S_FINISH;
                end
                else if (status.in_window)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_MARK:
            begin
                cmd.set_mark = !status.mark_set;
                state_next   = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (status.mark_set)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign rx_stall = stall_reg;

endmodule

// ===== hdl/srrw_dp.sv =====
module srrw_dp #(
    parameter int WINDOW_DEPTH    = 1024,
    parameter int SEGMENT_PAYLOAD = 1456
) (
    input  logic                clk,
    input  logic                rst_n,
    input  srrw_pkg::in_word_t  rx_word,
    input  srrw_pkg::cmd_t      cmd,
    output srrw_pkg::status_t   status,
    output srrw_pkg::out_word_t res_word,
    output logic                res_valid,
    input  logic                res_stall
);

    localparam int AW  = $clog2(WINDOW_DEPTH);
    localparam int PL  = $clog2(SEGMENT_PAYLOAD);
    localparam int QSH = 32 + PL;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W   = (AW+1)'(WINDOW_DEPTH);
    localparam logic [31:0]   DEPTH_32  = 32'(WINDOW_DEPTH);
    // 33-bit reciprocal, floor plus one: exact quotient for any 32-bit offset
    localparam logic [63:0]   RECIP     = ((64'd1 << QSH) / 64'(SEGMENT_PAYLOAD)) + 64'd1;
    localparam logic [16:0]   RECIP_LO  = RECIP[16:0];
    localparam logic [16:0]   RECIP_HI  = RECIP[33:17];

    logic [31:0]                    quo_reg,      quo_next;
    logic [48:0]                    acc_reg,      acc_next;
    logic [srrw_pkg::DIV_CNT_W-1:0] div_cnt_reg,  div_cnt_next;
    logic                           len_zero_reg, len_zero_next;
    logic                           store_reg,    store_next;
    logic [31:0]                    acked_reg,    acked_next;
    logic [AW-1:0]                  head_reg,     head_next;
    logic [AW-1:0]                  slot_reg;
    logic [AW-1:0]                  clear_cnt_reg, clear_cnt_next;
    srrw_pkg::out_word_t            out_word_reg, out_word_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           mark_rd_reg;

    logic                           mem [WINDOW_DEPTH];
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic                           mem_wdata;
    logic [AW-1:0]                  mem_raddr;

    // offset times the reciprocal: low half first, then high half
    logic [16:0]   mul_b;
    logic [48:0]   mul_p;
    logic [95:0]   prod_sum;
    logic [31:0]   seg_gap;
    logic          fwd;
    logic          in_win;
    logic [AW:0]   slot_sum;
    logic [AW:0]   slot_wrap;
    logic [AW-1:0] slot_calc;
    logic [AW-1:0] head_inc;
    logic          out_free;

    always_comb
    begin
        mul_b    = (div_cnt_reg == srrw_pkg::DIV_LAST) ? RECIP_HI : RECIP_LO;
        mul_p    = 49'(quo_reg) * 49'(mul_b);
        prod_sum = 96'(acc_reg) + (96'(mul_p) << 17);
    end

    always_comb
    begin
        fwd       = (quo_reg >= acked_reg);
        seg_gap   = quo_reg - acked_reg;
        in_win    = fwd && (seg_gap < DEPTH_32);
        slot_sum  = {1'b0, head_reg} + {1'b0, seg_gap[AW-1:0]};
        slot_wrap = slot_sum - DEPTH_W;
        slot_calc = (slot_sum >= DEPTH_W) ? slot_wrap[AW-1:0] : slot_sum[AW-1:0];
        head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
        out_free  = !out_valid_reg || !res_stall;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = head_reg;
        mem_wdata = 1'b0;
        if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
        end
        else if (cmd.set_mark)
        begin
            mem_we    = 1'b1;
            mem_waddr = slot_reg;
            mem_wdata = 1'b1;
        end
        else if (cmd.advance)
        begin
            mem_we = 1'b1;
        end

        if (cmd.rd_slot)
        begin
            mem_raddr = slot_calc;
        end
        else if (cmd.advance)
        begin
            mem_raddr = head_inc;
        end
        else
        begin
            mem_raddr = head_reg;
        end
    end

    always_comb
    begin
        quo_next       = quo_reg;
        acc_next       = acc_reg;
        div_cnt_next   = div_cnt_reg;
        len_zero_next  = len_zero_reg;
        store_next     = store_reg;
        acked_next     = acked_reg;
        head_next      = head_reg;
        clear_cnt_next = clear_cnt_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && res_stall;

        if (cmd.load)
        begin
            quo_next      = rx_word.seq_offset;
            div_cnt_next  = '0;
            len_zero_next = (rx_word.payload_length == '0);
            store_next    = 1'b0;
        end
        if (cmd.div_step)
        begin
            if (div_cnt_reg == srrw_pkg::DIV_LAST)
            begin
                quo_next = prod_sum[QSH +: 32];
            end
            else
            begin
                acc_next = mul_p;
            end
            div_cnt_next = div_cnt_reg + srrw_pkg::DIV_CNT_W'(1);
        end
        if (cmd.clear_step)
        begin
            clear_cnt_next = clear_cnt_reg + AW'(1);
        end
        if (cmd.set_mark)
        begin
            store_next = 1'b1;
        end
        if (cmd.advance)
        begin
            head_next  = head_inc;
            acked_next = acked_reg + 32'd1;
        end
        if (cmd.emit)
        begin
            out_word_next.ack_count     = acked_reg;
            out_word_next.ack_valid     = !len_zero_reg;
            out_word_next.store_payload = store_reg;
            out_word_next.transfer_done = len_zero_reg;
            out_valid_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg     <= '0;
            head_reg      <= '0;
            clear_cnt_reg <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acked_reg     <= acked_next;
            head_reg      <= head_next;
            clear_cnt_reg <= clear_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        acc_reg      <= acc_next;
        len_zero_reg <= len_zero_next;
        store_reg    <= store_next;
        slot_reg     <= slot_calc;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mark_rd_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        status.len_zero   = len_zero_reg;
        status.div_last   = (div_cnt_reg == srrw_pkg::DIV_LAST);
        status.fwd        = fwd;
        status.in_window  = in_win;
        status.mark_set   = mark_rd_reg;
        status.clear_last = (clear_cnt_reg == LAST_SLOT);
        status.out_free   = out_free;
    end

    assign res_word  = out_word_reg;
    assign res_valid = out_valid_reg;

endmodule

// ===== hdl/selective_repeat_receive_window.sv =====
// Flow: an end-of-transfer word goes from S_DIVIDE straight to S_FINISH; other words are
//   divided and looked up; an old segment then finishes, a segment inside the window is marked,
//   and any new segment then walks the head, releasing k segments (one bitmap read each).
// Throughput: one word in flight; rx_stall drops as the result loads, in the cycle that
//   res_valid rises; S_FINISH waits while res_stall holds the result register.
// Reset: async active low; then a clearing pass over all WINDOW_DEPTH slots with rx_stall high.
`include "selective_repeat_receive_window_macros.svh"

module selective_repeat_receive_window #(
    parameter int WINDOW_DEPTH    = 1024,
    parameter int SEGMENT_PAYLOAD = 1456
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  srrw_pkg::in_word_t  rx_word,
    output logic                res_valid,
    input  logic                res_stall,
    output srrw_pkg::out_word_t res_word
);

    srrw_pkg::cmd_t    cmd;
    srrw_pkg::status_t status;

    srrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .status   (status),
        .cmd      (cmd),
        .rx_stall (rx_stall)
    );

    srrw_dp #(
        .WINDOW_DEPTH    (WINDOW_DEPTH),
        .SEGMENT_PAYLOAD (SEGMENT_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_word   (rx_word),
        .cmd       (cmd),
        .status    (status),
        .res_word  (res_word),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

    `SRRW_ASSERT_NOW(a_done_no_ack, clk, rst_n, res_valid && res_word.transfer_done, !res_word.ack_valid && !res_word.store_payload)
    `SRRW_ASSERT_NOW(a_store_acked, clk, rst_n, res_valid && res_word.store_payload, res_word.ack_valid)
    `SRRW_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, rx_valid && !rx_stall, rx_stall)
    `SRRW_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, res_valid)

endmodule

// ===== tb/sv/tb_selective_repeat_receive_window.sv =====
`timescale 1ns / 100ps

module tb_selective_repeat_receive_window;

    localparam int WINDOW_DEPTH    = 1024;
    localparam int SEGMENT_PAYLOAD = 1456;
    localparam int SLOT_W          = $clog2(WINDOW_DEPTH);
    localparam int LEN_W           = srrw_pkg::LENGTH_W;
    localparam int NUM_ITEMS       = 800;
    localparam int STALL_MAX       = 14;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 64;

    // {ack_valid, store_payload, transfer_done}
    localparam logic [2:0] ACK_DONE  = 3'b001;
    localparam logic [2:0] ACK_ONLY  = 3'b100;
    localparam logic [2:0] ACK_STORE = 3'b110;

    typedef struct {
        srrw_pkg::in_word_t  word;
        bit                  known;
        srrw_pkg::out_word_t want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                rx_valid = 1'b0;
    logic                rx_stall;
    srrw_pkg::in_word_t  rx_word = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    srrw_pkg::out_word_t res_word;

    bit                window_marks [WINDOW_DEPTH];
    logic [SLOT_W-1:0] head_slot_q;
    logic [31:0]       acked_cnt;

    srrw_pkg::out_word_t pending_acks [$];
    int                  errors = 0;
    int                  sent_items;
    int                  idle_cycles = 0;
    bit                  rx_quiet;
    bit                  res_quiet = 1'b0;

    selective_repeat_receive_window #(
        .WINDOW_DEPTH    (WINDOW_DEPTH),
        .SEGMENT_PAYLOAD (SEGMENT_PAYLOAD)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_word   (rx_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    function automatic dir_row_t dir_row(logic [31:0] off, logic [LEN_W-1:0] len,
                                         bit known, logic [31:0] ack, logic [2:0] flags);
        dir_row_t r;
        r.word.seq_offset     = off;
        r.word.payload_length = len;
        r.known               = known;
        r.want                = srrw_pkg::out_word_t'({ack, flags});
        return r;
    endfunction

    function automatic srrw_pkg::in_word_t seg_word(logic [31:0] seg);
        srrw_pkg::in_word_t w;
        w.seq_offset = seg * SEGMENT_PAYLOAD + $urandom_range(0, SEGMENT_PAYLOAD - 1);
        if ($urandom_range(0, 9) == 0)
            w.payload_length = LEN_W'($urandom_range(SEGMENT_PAYLOAD + 1, 2047));
        else
            w.payload_length = LEN_W'($urandom_range(1, SEGMENT_PAYLOAD));
        return w;
    endfunction

    function automatic srrw_pkg::out_word_t window_update(srrw_pkg::in_word_t w);
        logic [31:0]         segment;
        logic [31:0]         seg_gap;
        logic [SLOT_W-1:0]   slot;
        srrw_pkg::out_word_t r;
        r = '0;
        if (w.payload_length == '0)
        begin
            r.ack_count     = acked_cnt;
            r.transfer_done = 1'b1;
            return r;
        end
        segment = w.seq_offset / SEGMENT_PAYLOAD;
        if (segment >= acked_cnt)
        begin
            seg_gap = segment - acked_cnt;
            if (seg_gap < WINDOW_DEPTH)
            begin
                slot = head_slot_q + seg_gap[SLOT_W-1:0];
                if (!window_marks[slot])
                begin
                    window_marks[slot] = 1'b1;
                    r.store_payload    = 1'b1;
                end
            end
            for (int n = 0; n < WINDOW_DEPTH && window_marks[head_slot_q]; n++)
            begin
                window_marks[head_slot_q] = 1'b0;
                head_slot_q = head_slot_q + 1'b1;
                acked_cnt   = acked_cnt + 32'd1;
            end
        end
        r.ack_count = acked_cnt;
        r.ack_valid = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_word(srrw_pkg::in_word_t w, bit known, srrw_pkg::out_word_t want);
        int                  gap;
        srrw_pkg::out_word_t pred;
        gap = idle_gap(rx_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_word  <= w;
        do @(posedge clk); while (rx_stall !== 1'b0);
        pred = window_update(w);
        pending_acks.push_back(known ? want : pred);
        sent_items++;
    endtask

    always @(posedge clk)
    begin
        if ((rx_valid === 1'b1 && rx_stall === 1'b0) ||
            (res_valid === 1'b1 && res_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall per word, then check against the oldest prediction
    initial
    begin
        int                  n;
        srrw_pkg::out_word_t want;
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                res_quiet = !res_quiet;
            n = idle_gap(res_quiet);
            @(negedge clk);
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!(res_valid === 1'b1 && res_stall === 1'b0));
            if (pending_acks.size() == 0)
                report_mismatch("unexpected word, ack_count", res_word.ack_count, 32'd0);
            else
            begin
                want = pending_acks.pop_front();
                if (res_word.ack_count !== want.ack_count)
                    report_mismatch("ack_count", res_word.ack_count, want.ack_count);
                if (res_word.ack_valid !== want.ack_valid)
                    report_mismatch("ack_valid", 32'(res_word.ack_valid),
                                    32'(want.ack_valid));
                if (res_word.store_payload !== want.store_payload)
                    report_mismatch("store_payload", 32'(res_word.store_payload),
                                    32'(want.store_payload));
                if (res_word.transfer_done !== want.transfer_done)
                    report_mismatch("transfer_done", 32'(res_word.transfer_done),
                                    32'(want.transfer_done));
            end
        end
    end

    initial
    begin
        dir_row_t           dir_rows [$];
        logic [31:0]        segs [$];
        logic [31:0]        base;
        logic [31:0]        tmp;
        srrw_pkg::in_word_t w;
        int                 n;
        int                 j;
        int                 pick;

        sent_items  = 0;
        rx_quiet    = 1'b0;
        foreach (window_marks[i])
            window_marks[i] = 1'b0;
        head_slot_q = '0;
        acked_cnt   = '0;

        dir_rows.push_back(dir_row(32'd0, 11'd0, 1'b1, 32'd0, ACK_DONE));
        dir_rows.push_back(dir_row(32'hFFFF_FFFF, 11'd1, 1'b1, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd0, 11'd1456, 1'b1, 32'd1, ACK_STORE));
        dir_rows.push_back(dir_row(32'd1455, 11'd1, 1'b1, 32'd1, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd1456 * 3, 11'd2047, 1'b1, 32'd1, ACK_STORE));
        dir_rows.push_back(dir_row(32'd1456 * 3 + 1455, 11'd7, 1'b1, 32'd1, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd1456 * 2, 11'd1, 1'b1, 32'd1, ACK_STORE));
        dir_rows.push_back(dir_row(32'd1456 + 1455, 11'd1456, 1'b1, 32'd4, ACK_STORE));
        dir_rows.push_back(dir_row(32'hFFFF_FFFF, 11'd0, 1'b1, 32'd4, ACK_DONE));
        // last slot of the window, then one past it
        dir_rows.push_back(dir_row(32'd1456 * 1027, 11'd1, 1'b1, 32'd4, ACK_STORE));
        dir_rows.push_back(dir_row(32'd1456 * 1028, 11'd1, 1'b1, 32'd4, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd1456 * 1028 - 1, 11'd1, 1'b1, 32'd4, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd1456 * 4, 11'd1024, 1'b0, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd0, 11'd1, 1'b0, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'h8000_0000, 11'h400, 1'b0, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'h7FFF_FFFF, 11'h3FF, 1'b0, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'h5555_5555, 11'h555, 1'b0, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'hAAAA_AAAA, 11'h2AA, 1'b0, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd1456 * 5, 11'h7FF, 1'b0, 32'd0, ACK_ONLY));
        dir_rows.push_back(dir_row(32'd1456 * 6 + 3, 11'd0, 1'b0, 32'd0, ACK_ONLY));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].want);

        while (sent_items < NUM_ITEMS + dir_rows.size())
        begin
            if ($urandom_range(0, 9) == 0)
                rx_quiet = !rx_quiet;
            pick = $urandom_range(0, 99);
            base = acked_cnt;
            if (pick < 60)
            begin
                // window filled out of order, with duplicates, stale and far segments
                n = $urandom_range(1, 40);
                segs.delete();
                for (int i = 0; i < n; i++)
                    segs.push_back(base + i);
                for (int i = n - 1; i > 0; i--)
                begin
                    j       = $urandom_range(0, i);
                    tmp     = segs[i];
                    segs[i] = segs[j];
                    segs[j] = tmp;
                end
                foreach (segs[i])
                begin
                    send_word(seg_word(segs[i]), 1'b0, '0);
                    if ($urandom_range(0, 9) == 0)
                        send_word(seg_word(segs[$urandom_range(0, i)]), 1'b0, '0);
                    if ($urandom_range(0, 19) == 0 && acked_cnt > 0)
                        send_word(seg_word($urandom_range(0, acked_cnt - 1)), 1'b0, '0);
                    if ($urandom_range(0, 19) == 0)
                        send_word(seg_word(acked_cnt + WINDOW_DEPTH +
                                           $urandom_range(0, 3000)), 1'b0, '0);
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    w.seq_offset     = $urandom;
                    w.payload_length = '0;
                    send_word(w, 1'b0, '0);
                end
            end
            else if (pick < 75)
            begin
                // long run behind a hole at the head, then the hole
                n = $urandom_range(50, 200);
                for (int i = 1; i <= n; i++)
                    send_word(seg_word(base + i), 1'b0, '0);
                send_word(seg_word(base), 1'b0, '0);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    w.seq_offset     = $urandom;
                    w.payload_length = LEN_W'($urandom_range(0, 2047));
                    send_word(w, 1'b0, '0);
                end
            end
        end

        @(negedge clk);
        rx_valid <= 1'b0;
        while (pending_acks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
